@@ design/postfix_stack_evaluator_assert.svh @@
// Assertion macros for the postfix stack evaluator
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/pse_pkg.sv @@
// Shared types and constants for the postfix stack evaluator
`default_nettype none
package pse_pkg;

  localparam int DATA_W          = 32;
  localparam int COUNT_W         = 5;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int DIV_CNT_W       = $clog2(DATA_W + 1);
  localparam int IN_TUSER_W      = 3;
  localparam int OUT_TUSER_W     = 2;
  localparam int OUT_TDATA_W     = ((DATA_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W       = OUT_TDATA_W - DATA_W - COUNT_W;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } pse_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } pse_status_t;

  typedef struct packed {
    logic        accept;
    logic        push;
    logic        rd;
    logic        start_div;
    logic        calc;
    logic        commit;
    logic        load_out;
    pse_status_t status;
  } pse_cmd_t;

  typedef struct packed {
    logic action;
    logic is_div;
    logic full;
    logic under;
    logic divz;
    logic div_done;
  } pse_flag_t;

endpackage
`default_nettype wire

@@ design/postfix_stack_evaluator.sv @@
// An accepted item passes through decode, then for an operator the calculate state
// (or the bit-serial divider for divide) and commit, before the result is loaded and out_tvalid rises.
// One item at a time: in_tready returns the cycle after the result is loaded, so
// the next item waits for the last one to finish; an unaccepted result holds back the next.
// Synchronous active-low reset empties the stack and clears both channels;
// stack memory contents are not cleared.
`default_nettype none
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // operand[31:0]
  input  wire logic [pse_pkg::DATA_W-1:0]      in_tdata,
  // action[0], operator_code[2:1]
  input  wire logic [pse_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // top_value[31:0], stack_count[36:32], zero[39:37]
  output logic [pse_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // status[1:0]
  output logic [pse_pkg::OUT_TUSER_W-1:0]      out_tuser
);
  import pse_pkg::*;

  pse_cmd_t  cmd;
  pse_flag_t flags;

  pse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .flags      (flags),
    .cmd        (cmd)
  );

  pse_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .flags     (flags),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

`include "postfix_stack_evaluator_assert.svh"

  `PSE_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "item taken while busy")
  `PSE_ASSERT_NOW(a_no_push_full, cmd.push, !flags.full, "push onto full stack")
  `PSE_ASSERT_NOW(a_no_pop_short, cmd.commit, !flags.under, "operator on short stack")
  `PSE_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_tvalid || out_tready, "result overwritten")

endmodule
`default_nettype wire

@@ design/pse_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module pse_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pse_pkg::DATA_W-1:0] num,
  input  wire logic [pse_pkg::DATA_W-1:0] den,
  output logic                            done,
  output logic [pse_pkg::DATA_W-1:0]      quot
);
  import pse_pkg::*;

  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    quo_r;
  logic [DATA_W-1:0]    dmag_r;
  logic                 neg_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      diff;

  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DATA_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= num[DATA_W-1] ? (DATA_W'(0) - num) : num;
      dmag_r <= den[DATA_W-1] ? (DATA_W'(0) - den) : den;
      neg_r  <= num[DATA_W-1] ^ den[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_r <= diff[DATA_W-1:0];
      end else begin
        rem_r <= rem_sh[DATA_W-1:0];
      end
      quo_r <= {quo_r[DATA_W-2:0], ~diff[DATA_W]};
    end
  end

  assign done = done_r;
  assign quot = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule
`default_nettype wire

@@ design/pse_ctrl.sv @@
// Sequencing state machine for the postfix stack evaluator
`default_nettype none
module pse_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  input  wire pse_pkg::pse_flag_t flags,
  output pse_pkg::pse_cmd_t       cmd
);
  import pse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CALC,
    S_DIV,
    S_COMMIT,
    S_RESP
  } state_t;

  state_t      state_r, state_nxt;
  pse_status_t st_r, st_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic        out_free;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    cmd.status     = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        st_nxt    = ST_OK;
        state_nxt = S_RESP;
        if (!flags.action) begin
          if (flags.full) begin
            st_nxt = ST_OVER;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (flags.under) begin
          st_nxt = ST_UNDER;
        end else if (flags.is_div && flags.divz) begin
          st_nxt = ST_DIVZ;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (flags.is_div) begin
          cmd.start_div = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.calc  = 1'b1;
          state_nxt = S_COMMIT;
        end
      end
      S_DIV: begin
        if (flags.div_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      st_r         <= ST_OK;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      st_r         <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule
`default_nettype wire

@@ design/pse_dpath.sv @@
// Stack memory, top-of-stack register, arithmetic and result register
`default_nettype none
module pse_dpath #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [pse_pkg::DATA_W-1:0]      in_tdata,
  input  wire logic [pse_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire pse_pkg::pse_cmd_t               cmd,
  output pse_pkg::pse_flag_t                   flags,
  output logic [pse_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [pse_pkg::OUT_TUSER_W-1:0]      out_tuser
);
  import pse_pkg::*;

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  // entries below the top; the top itself lives in top_r
  logic [DATA_W-1:0]      mem [STACK_DEPTH];
  logic [DATA_W-1:0]      rd_data_r;
  logic [DATA_W-1:0]      top_r;
  logic [DATA_W-1:0]      opd_r;
  logic [DATA_W-1:0]      res_r;
  logic [DATA_W-1:0]      alu;
  logic [DATA_W-1:0]      result;
  logic [DATA_W-1:0]      quot;
  logic                   act_r;
  pse_op_t                op_r;
  logic [SP_W-1:0]        sp_r;
  logic [SP_W-1:0]        sp_m1;
  logic [SP_W-1:0]        sp_m2;
  logic                   div_done;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;
  logic [DATA_W-1:0]      top_view;

  assign sp_m1 = sp_r - SP_W'(1);
  assign sp_m2 = sp_r - SP_W'(2);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= in_tuser[0];
      op_r  <= pse_op_t'(in_tuser[2:1]);
      opd_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && sp_r != '0) begin
      mem[sp_m1[IDX_W-1:0]] <= top_r;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[sp_m2[IDX_W-1:0]];
    end
  end

  always_comb begin
    case (op_r)
      OP_ADD:  alu = rd_data_r + top_r;
      OP_SUB:  alu = rd_data_r - top_r;
      OP_MUL:  alu = DATA_W'(rd_data_r * top_r);
      default: alu = rd_data_r + top_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      res_r <= alu;
    end
  end

  pse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start_div),
    .num   (rd_data_r),
    .den   (top_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign result = (op_r == OP_DIV) ? quot : res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.push) begin
      sp_r <= sp_r + SP_W'(1);
    end else if (cmd.commit) begin
      sp_r <= sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_r <= opd_r;
    end else if (cmd.commit) begin
      top_r <= result;
    end
  end

  assign top_view = (sp_r == '0) ? '0 : top_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, COUNT_W'(sp_r), top_view};
      out_tuser_r <= cmd.status;
    end
  end

  assign flags.action   = act_r;
  assign flags.is_div   = (op_r == OP_DIV);
  assign flags.full     = (sp_r == SP_W'(STACK_DEPTH));
  assign flags.under    = (sp_r < SP_W'(2));
  assign flags.divz     = (top_r == '0);
  assign flags.div_done = div_done;

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule
`default_nettype wire
